// ===== design/fdas_pkg.sv =====
// shared types and constants for the frame deframer with additive sum check
`default_nettype none
package fdas_pkg;

  localparam int MinFrame   = 8;
  localparam int TrailerLen = 4;
  localparam int HeaderLen  = 3;
  localparam int QueueDepth = 4;

  localparam int PosW   = 4;
  localparam int QCntW  = $clog2(QueueDepth + 1);
  localparam int QPtrW  = $clog2(QueueDepth);
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROOM_ID    = 8'd0,
    REG_ROOM_CHECK = 8'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_ROOM_BAD  = 2'd2,
    ST_SUM_BAD   = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] message_id;
    status_t     status;
    logic        frame_last;
  } result_t;

  // results produced by one accepted byte, packed from slot 0
  typedef struct packed {
    logic [1:0] count;
    result_t    slot1;
    result_t    slot0;
  } push_t;

endpackage
`default_nettype wire

// ===== design/fdas_core.sv =====
// frame state: delay line, position, running sum, id and room check
`default_nettype none
module fdas_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  input  wire logic [7:0]      room_id,
  input  wire logic            room_check,
  output fdas_pkg::push_t      push
);
  import fdas_pkg::*;

  logic [7:0]      delay_bytes [TrailerLen];
  logic [PosW-1:0] byte_position;
  logic [31:0]     running_sum;
  logic [15:0]     held_message_id;
  logic            room_bad;

  logic [7:0]      delay_next [TrailerLen];
  logic [PosW-1:0] pos_next;
  logic [31:0]     sum_next;
  logic [15:0]     id_next;
  logic            room_bad_next;
  logic            in_body;
  logic            emit_pay;
  logic [31:0]     trailer;
  status_t         st;
  result_t         pay_res;
  result_t         stat_res;

  always_comb begin
    in_body  = byte_position >= PosW'(HeaderLen);
    emit_pay = byte_position >= PosW'(HeaderLen + TrailerLen);

    room_bad_next = room_bad;
    if (byte_position == '0) begin
      room_bad_next = room_check && (in_byte != room_id);
    end

    id_next = held_message_id;
    if (byte_position == PosW'(1)) begin
      id_next[7:0] = in_byte;
    end
    if (byte_position == PosW'(2)) begin
      id_next[15:8] = in_byte;
    end

    sum_next = running_sum + (emit_pay ? {24'd0, delay_bytes[0]} : 32'd0);

    for (int i = 0; i < TrailerLen; i++) begin
      delay_next[i] = delay_bytes[i];
    end
    if (in_body) begin
      for (int i = 0; i < TrailerLen - 1; i++) begin
        delay_next[i] = delay_bytes[i + 1];
      end
      delay_next[TrailerLen - 1] = in_byte;
    end

    pos_next = (byte_position < PosW'(MinFrame)) ? byte_position + PosW'(1) : byte_position;

    trailer = {delay_next[3], delay_next[2], delay_next[1], delay_next[0]};
    // short frame wins over room, room over sum
    if (byte_position < PosW'(MinFrame - 1)) begin
      st = ST_SHORT;
    end else if (room_bad_next) begin
      st = ST_ROOM_BAD;
    end else if (trailer != sum_next) begin
      st = ST_SUM_BAD;
    end else begin
      st = ST_OK;
    end

    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = delay_bytes[0];
    pay_res.message_id   = held_message_id;
    pay_res.status       = ST_OK;
    pay_res.frame_last   = 1'b0;

    stat_res.kind         = KIND_STATUS;
    stat_res.payload_byte = 8'd0;
    stat_res.message_id   = id_next;
    stat_res.status       = st;
    stat_res.frame_last   = 1'b1;

    push.count = {1'b0, emit_pay} + {1'b0, in_last};
    push.slot0 = emit_pay ? pay_res : stat_res;
    push.slot1 = stat_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      for (int i = 0; i < TrailerLen; i++) begin
        delay_bytes[i] <= 8'd0;
      end
      byte_position   <= '0;
      running_sum     <= 32'd0;
      held_message_id <= 16'd0;
      room_bad        <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < TrailerLen; i++) begin
        delay_bytes[i] <= delay_next[i];
      end
      byte_position   <= pos_next;
      running_sum     <= sum_next;
      held_message_id <= id_next;
      room_bad        <= room_bad_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/fdas_outq.sv =====
// result queue: takes up to two results per cycle, hands out one per transfer
`default_nettype none
module fdas_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_en,
  input  wire fdas_pkg::push_t      push,
  input  wire logic                 pop,
  output fdas_pkg::result_t         head,
  output logic                      not_empty,
  output logic [fdas_pkg::QCntW-1:0] level
);
  import fdas_pkg::*;

  result_t          entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic [QCntW-1:0] count_next;
  logic [QCntW-1:0] n_push;

  always_comb begin
    n_push     = push_en ? QCntW'(push.count) : '0;
    count_next = count + n_push - QCntW'(pop);
    head       = entries[rd_ptr];
    not_empty  = count != '0;
    level      = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(n_push);
      rd_ptr <= rd_ptr + QPtrW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && push.count != 2'd0) begin
      entries[wr_ptr] <= push.slot0;
    end
    if (push_en && push.count == 2'd2) begin
      entries[wr_ptr + QPtrW'(1)] <= push.slot1;
    end
  end

endmodule
`default_nettype wire

// ===== design/frame_deframer_additive_sum.sv =====
// Frame deframer with additive sum check. One byte is taken per cycle while
// in_stall is low; the frame state updates at the transfer and its results
// go into a four-entry result queue. A byte gives no result, one (payload
// or status) or two (the last payload byte and then the status). in_stall
// rises while more than two results wait in the queue, so with out_stall
// low the block sustains one byte per cycle. Payload bytes leave four bytes
// after they arrive and are to be trusted only when the frame's status
// result reads ok. room_id and room_check are sampled when a frame's first
// byte arrives.
`default_nettype none
module frame_deframer_additive_sum (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [fdas_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [fdas_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_kind,
  output logic [7:0]                         payload_byte,
  output logic [15:0]                        message_id,
  output logic [1:0]                         status,
  output logic                               frame_last
);
  import fdas_pkg::*;

  logic [7:0]       room_id;
  logic             room_check;
  logic             accept;
  logic             pop;
  push_t            push;
  result_t          head;
  logic             not_empty;
  logic [QCntW-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_id    <= 8'd0;
      room_check <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROOM_ID:    room_id    <= cfg_data[7:0];
        REG_ROOM_CHECK: room_check <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // room for two more results is needed before a byte transfer
  assign in_stall = level > QCntW'(QueueDepth - 2);
  assign accept   = in_valid && !in_stall;
  assign pop      = not_empty && !out_stall;

  fdas_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .room_id    (room_id),
    .room_check (room_check),
    .push       (push)
  );

  fdas_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_en   (accept),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  assign out_valid    = not_empty;
  assign out_kind     = head.kind;
  assign payload_byte = head.payload_byte;
  assign message_id   = head.message_id;
  assign status       = head.status;
  assign frame_last   = head.frame_last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QCntW'(QueueDepth))
    else $error("result queue overfilled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> out_valid)
    else $error("closing byte left no result");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_PAYLOAD |-> status == ST_OK && !frame_last)
    else $error("payload result carries status fields");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_STATUS |-> frame_last && payload_byte == 8'd0)
    else $error("status result malformed");

endmodule
`default_nettype wire

// ===== bench/fdas_frame_checker.sv =====
// checker for the frame deframer: predicts the results of each byte transfer and compares them
module fdas_frame_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [fdas_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fdas_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_kind,
  input  logic [7:0]                    payload_byte,
  input  logic [15:0]                   message_id,
  input  logic [1:0]                    status,
  input  logic                          frame_last,
  output int                            mismatches,
  output int                            outstanding
);
  import fdas_pkg::*;

  logic [7:0]      room_id_q;
  logic            room_check_q;
  logic [7:0]      trail [TrailerLen];
  logic [PosW-1:0] seen;
  logic [31:0]     payload_sum;
  logic [15:0]     frame_id;
  logic            room_bad;
  result_t         due_results [$];

  task automatic clear_frame();
    foreach (trail[i]) trail[i] = 8'h00;
    seen = '0;
    payload_sum = '0;
    frame_id = '0;
    room_bad = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    logic [PosW-1:0] at;
    result_t r;
    at = seen;
    if (at == 0) begin
      room_bad = room_check_q && (b != room_id_q);
    end else if (at == 1) begin
      frame_id[7:0] = b;
    end else if (at == 2) begin
      frame_id[15:8] = b;
    end else begin
      // the trailer window is full, so its oldest byte is payload
      if (at >= HeaderLen + TrailerLen) begin
        payload_sum = payload_sum + trail[0];
        r.kind = KIND_PAYLOAD;
        r.payload_byte = trail[0];
        r.message_id = frame_id;
        r.status = ST_OK;
        r.frame_last = 1'b0;
        due_results.push_back(r);
      end
      trail[0] = trail[1];
      trail[1] = trail[2];
      trail[2] = trail[3];
      trail[3] = b;
    end
    if (at < MinFrame) seen = at + 1'b1;
    if (lst) begin
      r.kind = KIND_STATUS;
      r.payload_byte = 8'h00;
      r.message_id = frame_id;
      r.frame_last = 1'b1;
      if (at + 1 < MinFrame) r.status = ST_SHORT;
      else if (room_bad) r.status = ST_ROOM_BAD;
      else if ({trail[3], trail[2], trail[1], trail[0]} != payload_sum) r.status = ST_SUM_BAD;
      else r.status = ST_OK;
      due_results.push_back(r);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      room_id_q = 8'h00;
      room_check_q = 1'b0;
      clear_frame();
      due_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_ROOM_ID) room_id_q = cfg_data[7:0];
        else if (cfg_index == REG_ROOM_CHECK) room_check_q = cfg_data[0];
      end
      if (in_valid && !in_stall) deframe_byte(in_byte, in_last);
      if (out_valid && !out_stall) begin
        got.kind = kind_t'(out_kind);
        got.payload_byte = payload_byte;
        got.message_id = message_id;
        got.status = status_t'(status);
        got.frame_last = frame_last;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d byte %02h id %04h status %0d last %0d",
                     got.kind, got.payload_byte, got.message_id, got.status, got.frame_last);
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
              got.message_id !== want.message_id || got.status !== want.status ||
              got.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected kind %0d byte %02h id %04h status %0d ",
                        "last %0d, got kind %0d byte %02h id %04h status %0d last %0d"},
                       want.kind, want.payload_byte, want.message_id, want.status,
                       want.frame_last, got.kind, got.payload_byte, got.message_id,
                       got.status, got.frame_last);
          end
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

// ===== bench/tb_frame_deframer_additive_sum.sv =====
// testbench top for the frame deframer: drives frames and config, gives the verdict
module tb_frame_deframer_additive_sum;
  import fdas_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 8'd2;
  localparam int WatchLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 200;
  localparam int Phases = 8;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = 8'h00;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_kind;
  logic [7:0]         payload_byte;
  logic [15:0]        message_id;
  logic [1:0]         status;
  logic               frame_last;

  int                 mismatches;
  int                 outstanding;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles = 0;
  int                 hold_count = 0;
  logic               hold_arm = 1'b0;
  logic               hold_spent = 1'b0;
  logic [7:0]         room_now = 8'h00;
  logic [7:0]         frame_bytes [$];

  frame_deframer_additive_sum dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .payload_byte(payload_byte), .message_id(message_id), .status(status),
    .frame_last(frame_last)
  );

  fdas_frame_checker frame_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .payload_byte(payload_byte), .message_id(message_id), .status(status),
    .frame_last(frame_last), .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: one long hold-off when armed, random stalls otherwise
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_arm && !hold_spent) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count == HoldCycles - 1) hold_spent <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= lst;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic ship_frame();
    foreach (frame_bytes[i]) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // stop sending and wait out every expected result
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_room(input logic [7:0] id, input logic chk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROOM_ID;
    cfg_data <= id;
    @(posedge clk);
    cfg_index <= REG_ROOM_CHECK;
    cfg_data <= {7'($urandom), chk};
    @(posedge clk);
    // an index past the register list must be ignored
    cfg_index <= RegUnused;
    cfg_data <= 8'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    room_now = id;
  endtask

  initial begin
    int         sent;
    int         pick;
    int         plen;
    logic [31:0] acc;
    logic [7:0] rb;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_room(8'h3C, 1'b1);
    // good frame with extreme payload bytes
    frame_bytes = {8'h3C, 8'h34, 8'h12, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    ship_frame();
    // wrong room byte with checking on
    frame_bytes = {8'h11, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00};
    ship_frame();
    // short frame, header only
    frame_bytes = {8'h3C, 8'hAB, 8'hCD};
    ship_frame();
    // trailer disagrees with the payload sum
    frame_bytes = {8'h3C, 8'h00, 8'h00, 8'h07, 8'h01, 8'h00, 8'h00, 8'h00};
    ship_frame();
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0, 5: set_room(8'h00, ph == 5);
        1, 7: set_room(8'hFF, ph == 1);
        default: set_room(8'($urandom), ph % 2 == 0);
      endcase
      send_idle_pct = (ph % 4 == 1) ? 75 : (ph % 4 == 3) ? 20 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 75 : (ph % 4 == 3) ? 20 : 0;
      if (ph == 4) hold_arm <= 1'b1;
      sent = 0;
      while (sent < PhaseBytes) begin
        frame_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 75) begin
          frame_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom) : room_now);
          frame_bytes.push_back(8'($urandom));
          frame_bytes.push_back(8'($urandom));
          plen = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(12);
          acc = '0;
          repeat (plen) begin
            rb = 8'($urandom);
            acc = acc + rb;
            frame_bytes.push_back(rb);
          end
          if ($urandom_range(9) == 0) acc[$urandom_range(31)] ^= 1'b1;
          frame_bytes.push_back(acc[7:0]);
          frame_bytes.push_back(acc[15:8]);
          frame_bytes.push_back(acc[23:16]);
          frame_bytes.push_back(acc[31:24]);
        end else if (pick < 88) begin
          repeat ($urandom_range(1, 7)) frame_bytes.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(8, 24)) frame_bytes.push_back(8'($urandom));
        end
        ship_frame();
        sent += frame_bytes.size();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
